// ===== src/sha256_pkg.sv =====
// Shared types, constants and functions for the SHA-256 stream hasher.
`timescale 1ns / 1ps
package sha256_pkg;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUNDS,
        ST_FOLD,
        ST_LEN,
        ST_EMIT
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic take_byte;   // store the input byte, count it
        logic put_pad;     // store 0x80 at the current position
        logic put_len;     // write the bit length into words 14 and 15
        logic start;       // load working vars from hash state, round 0
        logic round;       // run one round
        logic fold;        // add working vars to hash state, clear buffer
        logic restart;     // load initial hash, clear counter and buffer
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic block_full;  // next byte fills the block
        logic pad_late;    // pad position is 56 or above
        logic last_round;  // round 63 is running
    } t_stat;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ===== src/sha256_datapath.sv =====
// SHA-256 datapath: block buffer, byte count, hash state and round unit.
`timescale 1ns / 1ps
module sha256_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sha256_pkg::t_cmd   i_cmd,
    input  logic [7:0]         i_byte,
    input  logic [1:0]         i_word_sel,
    output sha256_pkg::t_stat  o_stat,
    output logic [63:0]        o_digest_word
);
    import sha256_pkg::*;

    logic [31:0] r_buf [16];
    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [63:0] r_count;
    logic [5:0]  r_round;

    logic [5:0]  pos;
    logic [7:0]  put_val;
    logic [31:0] put_mask;
    logic [63:0] bits;
    logic [31:0] w15, w2, g0, g1, wt, s1, ch, t1, s0, mj, t2;

    assign pos  = r_count[5:0];
    assign bits = {r_count[60:0], 3'b000};
    assign put_val  = i_cmd.put_pad ? PAD_BYTE : i_byte;
    assign put_mask = {24'd0, put_val} << (5'd24 - {pos[1:0], 3'b000});

    // Schedule and round logic
    always_comb begin
        w15 = r_buf[r_round[3:0] + 4'd1];
        w2  = r_buf[r_round[3:0] + 4'd14];
        g0  = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
        g1  = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
        if (r_round < 6'd16) begin
            wt = r_buf[r_round[3:0]];
        end else begin
            wt = r_buf[r_round[3:0]] + g0 + r_buf[r_round[3:0] + 4'd9] + g1;
        end
        s1 = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
        ch = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        t1 = r_v[7] + s1 + ch + ROUND_K[r_round] + wt;
        s0 = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
        mj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t2 = s0 + mj;
    end

    assign o_stat.block_full = (pos == 6'd63);
    assign o_stat.pad_late   = (pos >= 6'd56);
    assign o_stat.last_round = (r_round == 6'd63);
    assign o_digest_word = {r_h[{i_word_sel, 1'b0}], r_h[{i_word_sel, 1'b1}]};

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.restart) begin
            r_h     <= INIT_H;
            r_count <= '0;
            r_round <= '0;
            for (int i = 0; i < 16; i++) r_buf[i] <= '0;
        end else begin
            if (i_cmd.take_byte || i_cmd.put_pad) begin
                r_buf[pos[5:2]] <= r_buf[pos[5:2]] | put_mask;
            end
            if (i_cmd.take_byte) begin
                r_count <= r_count + 64'd1;
            end
            if (i_cmd.put_len) begin
                r_buf[14] <= bits[63:32];
                r_buf[15] <= bits[31:0];
            end
            if (i_cmd.start) begin
                r_v     <= r_h;
                r_round <= '0;
            end
            if (i_cmd.round) begin
                if (r_round >= 6'd16) r_buf[r_round[3:0]] <= wt;
                r_v[7] <= r_v[6];
                r_v[6] <= r_v[5];
                r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + t1;
                r_v[3] <= r_v[2];
                r_v[2] <= r_v[1];
                r_v[1] <= r_v[0];
                r_v[0] <= t1 + t2;
                r_round <= r_round + 6'd1;
            end
            if (i_cmd.fold) begin
                for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                for (int i = 0; i < 16; i++) r_buf[i] <= '0;
            end
        end
    end
endmodule

// ===== src/sha256_ctrl.sv =====
// SHA-256 controller: input handshake, block sequencing and digest output.
`timescale 1ns / 1ps
module sha256_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_byte_valid,
    input  logic               i_eom,
    output logic               o_ready,
    input  sha256_pkg::t_stat  i_stat,
    output sha256_pkg::t_cmd   o_cmd,
    output logic               o_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_word_sel
);
    import sha256_pkg::*;

    t_state r_state, n_state;
    logic   r_final, n_final;   // compressing the final block
    logic   r_pend, n_pend;     // finish still owed after this block
    logic   r_lenblk, n_lenblk; // a length-only block still follows
    logic [1:0] r_sel, n_sel;
    logic   acc;

    assign acc = i_valid && o_ready;

    // Next state
    always_comb begin
        n_state = r_state; n_final = r_final; n_pend = r_pend;
        n_lenblk = r_lenblk; n_sel = r_sel;
        case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    if (i_byte_valid && i_stat.block_full) begin
                        n_state = ST_ROUNDS; n_pend = i_eom; n_final = 1'b0;
                    end else if (i_eom) begin
                        n_state = ST_PAD;
                    end
                end
            end
            // pad goes in after the last byte has landed
            ST_PAD: begin
                n_state = ST_ROUNDS;
                n_final = !i_stat.pad_late;
                n_lenblk = i_stat.pad_late;
            end
            ST_ROUNDS: if (i_stat.last_round) n_state = ST_FOLD;
            ST_FOLD: begin
                if (r_pend) begin
                    n_state = ST_PAD; n_pend = 1'b0;
                end else if (r_lenblk) begin
                    n_state = ST_LEN; n_lenblk = 1'b0;
                end else if (r_final) begin
                    n_state = ST_EMIT; n_sel = 2'd0;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_LEN: begin
                n_state = ST_ROUNDS; n_final = 1'b1;
            end
            ST_EMIT: begin
                if (i_out_ready) begin
                    n_sel = r_sel + 2'd1;
                    if (r_sel == 2'd3) begin
                        n_state = ST_IDLE; n_final = 1'b0;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd = '0;
        o_ready = (r_state == ST_IDLE);
        o_valid = (r_state == ST_EMIT);
        o_word_sel = r_sel;
        case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    o_cmd.take_byte = i_byte_valid;
                    o_cmd.start = i_byte_valid && i_stat.block_full;
                end
            end
            ST_PAD: begin
                o_cmd.put_pad = 1'b1;
                o_cmd.start = 1'b1;
            end
            ST_ROUNDS: o_cmd.round = 1'b1;
            ST_FOLD: o_cmd.fold = 1'b1;
            ST_LEN: begin
                o_cmd.put_len = 1'b1;
                o_cmd.start = 1'b1;
            end
            ST_EMIT: o_cmd.restart = i_out_ready && (r_sel == 2'd3);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE; r_final <= 1'b0; r_pend <= 1'b0;
            r_lenblk <= 1'b0; r_sel <= 2'd0;
        end else begin
            r_state <= n_state; r_final <= n_final; r_pend <= n_pend;
            r_lenblk <= n_lenblk; r_sel <= n_sel;
        end
    end
endmodule

// ===== src/sha256_seq.sv =====
// Final-block length placement: adds the length words beside an early pad.
`timescale 1ns / 1ps
module sha256_seq (
    input  sha256_pkg::t_cmd   i_cmd,
    input  sha256_pkg::t_stat  i_stat,
    output sha256_pkg::t_cmd   o_cmd
);
    import sha256_pkg::*;

    // Length shares the pad block unless the pad landed in the last eight bytes
    always_comb begin
        o_cmd = i_cmd;
        if (i_cmd.put_pad && !i_stat.pad_late) o_cmd.put_len = 1'b1;
    end
endmodule

// ===== src/sha256_stream_hasher.sv =====
// SHA-256 stream hasher top level: byte stream in, four digest words out.
// A byte is taken each cycle unless it fills a block; then tready drops while that
// block runs 64 rounds and one fold. After the end item the pad block is hashed,
// after the full block if the end byte fills one, and before a length-only block if
// the pad lands in the last eight bytes; four items follow, one per ready cycle.
// Synchronous active-low reset loads the initial hash and clears all counts.
`timescale 1ns / 1ps
module sha256_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // byte_valid
    input  logic        s_axis_tlast,   // end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [63:0] digest_word
    output logic [1:0]  m_axis_tuser,   // [1:0] word_index
    output logic        m_axis_tlast    // last_word
);
    import sha256_pkg::*;

    t_cmd   ctrl_cmd;
    t_cmd   dp_cmd;
    t_stat  stat;
    logic [1:0] word_sel;

    assign m_axis_tuser = word_sel;
    assign m_axis_tlast = (word_sel == 2'd3);

    sha256_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .i_byte_valid (s_axis_tuser),
        .i_eom        (s_axis_tlast),
        .o_ready      (s_axis_tready),
        .i_stat       (stat),
        .o_cmd        (ctrl_cmd),
        .o_valid      (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_word_sel   (word_sel)
    );

    sha256_seq u_seq (
        .i_cmd  (ctrl_cmd),
        .i_stat (stat),
        .o_cmd  (dp_cmd)
    );

    sha256_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .i_byte        (s_axis_tdata),
        .i_word_sel    (word_sel),
        .o_stat        (stat),
        .o_digest_word (m_axis_tdata)
    );
endmodule
